// ===== rtl/core/isqe_pkg.sv =====
package isqe_pkg;

  // Fixed field widths
  localparam int unsigned CAND_W     = 16;
  localparam int unsigned IDX_IN_W   = 4;
  localparam int unsigned COEF_IN_W  = 24;
  localparam int unsigned ENERGY_W   = 40;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned SPIN_CNT_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_SPINS  = 16;
  localparam int unsigned DEF_COEF_WIDTH = 24;

  // Reset values of the configuration registers
  localparam logic [SPIN_CNT_W-1:0] SPIN_CNT_RST = SPIN_CNT_W'(16);

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Energy mode codes
  localparam logic MODE_ISING = 1'b0;
  localparam logic MODE_QUBO  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPINS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(2);

  // Input word
  typedef struct packed {
    logic                        cmd;
    logic [IDX_IN_W-1:0]         row_index;
    logic [IDX_IN_W-1:0]         col_index;
    logic signed [COEF_IN_W-1:0] coef_value;
    logic [CAND_W-1:0]           candidate;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic [CAND_W-1:0]          candidate_echo;
  } out_word_t;

  // Configuration register set
  typedef struct packed {
    logic                       energy_mode;
    logic [SPIN_CNT_W-1:0]      spin_count;
    logic signed [OFFSET_W-1:0] energy_offset;
  } cfg_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_stat_t;

endpackage

// ===== rtl/core/isqe_coef_mem.sv =====
module isqe_coef_mem #(
  parameter int unsigned MAX_SPINS  = isqe_pkg::DEF_MAX_SPINS,
  parameter int unsigned COEF_WIDTH = isqe_pkg::DEF_COEF_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [2*$clog2(MAX_SPINS)-1:0]      wr_addr_i,
  input  logic signed [COEF_WIDTH-1:0]        wr_data_i,
  input  logic                                rd_en_i,
  input  logic [2*$clog2(MAX_SPINS)-1:0]      rd_addr_i,
  output logic signed [COEF_WIDTH-1:0]        rd_data_o
);
  import isqe_pkg::*;

  localparam int unsigned ADDR_W = 2 * $clog2(MAX_SPINS);
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  logic [COEF_WIDTH-1:0] mem_q [DEPTH];
  logic [COEF_WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = signed'(rd_data_q);

endmodule

// ===== rtl/core/isqe_seq.sv =====
module isqe_seq #(
  parameter int unsigned MAX_SPINS  = isqe_pkg::DEF_MAX_SPINS,
  parameter int unsigned COEF_WIDTH = isqe_pkg::DEF_COEF_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [isqe_pkg::CAND_W-1:0]          cand_i,
  input  isqe_pkg::cfg_t                       cfg_i,
  output logic                                 rd_en_o,
  output logic [2*$clog2(MAX_SPINS)-1:0]       rd_addr_o,
  input  logic signed [COEF_WIDTH-1:0]         rd_data_i,
  input  logic                                 res_take_i,
  output isqe_pkg::seq_stat_t                  stat_o,
  output logic signed [isqe_pkg::ENERGY_W-1:0] energy_o,
  output logic [isqe_pkg::CAND_W-1:0]          cand_o
);
  import isqe_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SPINS);
  localparam int unsigned NW     = $clog2(MAX_SPINS + 1);
  localparam int unsigned NTERMS = MAX_SPINS * (MAX_SPINS + 1) / 2;
  localparam int unsigned WIDE_W = (COEF_WIDTH > OFFSET_W) ? COEF_WIDTH : OFFSET_W;
  localparam int unsigned RAW_W  = WIDE_W + $clog2(NTERMS + 1) + 1;
  localparam int unsigned ACC_W  = (RAW_W > ENERGY_W + 1) ? RAW_W : ENERGY_W + 1;
  localparam int unsigned POS_W  = $clog2(CAND_W);

  localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_HOLD
  } state_e;

  state_e                    state_q, state_d;
  logic [IDX_W-1:0]          j_q, j_d, k_q, k_d;
  logic [NW-1:0]             n_q, n_d, n_eff;
  logic [MAX_SPINS-1:0]      vars_q, vars_d;
  logic                      mode_q, mode_d;
  logic [CAND_W-1:0]         cand_q, cand_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      tag_vld_q, tag_vld_d;
  logic                      tag_bj_q, tag_bj_d;
  logic                      tag_bk_q, tag_bk_d;
  logic                      tag_diag_q, tag_diag_d;

  logic                      k_last, j_last;
  logic signed [ACC_W-1:0]   c_ext, term;
  logic                      neg;
  logic [ACC_W-ENERGY_W:0]   acc_hi;

  // Spin count clamped to the store size
  always_comb begin
    if (32'(cfg_i.spin_count) > MAX_SPINS) begin
      n_eff = NW'(MAX_SPINS);
    end else begin
      n_eff = NW'(cfg_i.spin_count);
    end
  end

  // Variable j is candidate bit n-1-j, zero past the candidate width
  always_comb begin
    int pos;
    vars_d = '0;
    for (int j = 0; j < MAX_SPINS; j++) begin
      pos = int'(n_eff) - 1 - j;
      if (pos >= 0 && pos < CAND_W) begin
        vars_d[j] = cand_i[pos[POS_W-1:0]];
      end
    end
  end

  assign k_last = (NW'(k_q) + NW'(1)) == n_q;
  assign j_last = (NW'(j_q) + NW'(1)) == n_q;

  // Term of the entry read last cycle
  assign c_ext = ACC_W'(rd_data_i);
  assign neg   = tag_diag_q ? tag_bj_q : (tag_bj_q ^ tag_bk_q);
  always_comb begin
    if (mode_q == MODE_QUBO) begin
      term = (tag_bj_q && tag_bk_q) ? c_ext : '0;
    end else begin
      term = neg ? -c_ext : c_ext;
    end
  end

  // Sequencer: walk the upper triangle, one entry per cycle
  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    k_d        = k_q;
    n_d        = n_q;
    mode_d     = mode_q;
    cand_d     = cand_q;
    acc_d      = acc_q;
    tag_vld_d  = 1'b0;
    tag_bj_d   = vars_q[j_q];
    tag_bk_d   = vars_q[k_q];
    tag_diag_d = (j_q == k_q);

    if (tag_vld_q) begin
      acc_d = acc_q + term;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          j_d    = '0;
          k_d    = '0;
          n_d    = n_eff;
          mode_d = cfg_i.energy_mode;
          cand_d = cand_i;
          acc_d  = (cfg_i.energy_mode == MODE_QUBO) ? ACC_W'(cfg_i.energy_offset) : '0;
          state_d = (n_eff == '0) ? S_HOLD : S_RUN;
        end
      end
      S_RUN: begin
        tag_vld_d = 1'b1;
        if (k_last) begin
          if (j_last) begin
            state_d = S_DRAIN;
          end else begin
            j_d = j_q + IDX_W'(1);
            k_d = j_q + IDX_W'(1);
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tag_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tag_vld_q <= tag_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    k_q        <= k_d;
    n_q        <= n_d;
    mode_q     <= mode_d;
    cand_q     <= cand_d;
    acc_q      <= acc_d;
    tag_bj_q   <= tag_bj_d;
    tag_bk_q   <= tag_bk_d;
    tag_diag_q <= tag_diag_d;
    if (state_q == S_IDLE && start_i) begin
      vars_q <= vars_d;
    end
  end

  // Saturate the final sum
  assign acc_hi = acc_q[ACC_W-1:ENERGY_W-1];
  always_comb begin
    if (acc_hi == '0 || acc_hi == '1) begin
      energy_o = acc_q[ENERGY_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      energy_o = E_MIN;
    end else begin
      energy_o = E_MAX;
    end
  end

  assign cand_o           = cand_q;
  assign rd_en_o          = (state_q == S_RUN);
  assign rd_addr_o        = {j_q, k_q};
  assign stat_o.idle      = (state_q == S_IDLE);
  assign stat_o.res_valid = (state_q == S_HOLD);

endmodule

// ===== rtl/core/ising_qubo_energy_evaluator.sv =====
// Ising / QUBO energy evaluator. Load words (cmd load) write one coefficient of the
// upper-triangular matrix into a coefficient memory with separate write and read
// ports; loads outside the store are dropped and produce no result. An evaluate word
// (cmd eval) walks the upper triangle of the first n = min(spin_count, MAX_SPINS)
// variables, reading and accumulating one coefficient per cycle through the memory's
// one read port, so an evaluation makes n*(n+1)/2 reads (136 reads for 16 spins)
// before the next word is taken. The energy is summed exactly and saturated to 40
// bits; in QUBO mode the offset is added. Configuration registers (mode, spin count,
// offset at indexes 0, 1, 2) may be written only while the block is idle; the store
// has no reset, and every coefficient an evaluation reads must have been loaded.
module ising_qubo_energy_evaluator #(
  parameter int unsigned MAX_SPINS  = isqe_pkg::DEF_MAX_SPINS,
  parameter int unsigned COEF_WIDTH = isqe_pkg::DEF_COEF_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  isqe_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output isqe_pkg::out_word_t               out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [isqe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [isqe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import isqe_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SPINS);
  localparam int unsigned ADDR_W = 2 * IDX_W;

  cfg_t                     cfg_q;
  seq_stat_t                stat;
  logic                     in_acc, load_we, res_take;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic signed [COEF_WIDTH-1:0] wr_data, rd_data;
  logic                     rd_en;
  logic signed [ENERGY_W-1:0] energy;
  logic [CAND_W-1:0]        cand_res;
  logic                     out_valid_q;
  out_word_t                out_word_q;

  // Input handshake
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = !stat.idle;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.energy_mode   <= MODE_ISING;
      cfg_q.spin_count    <= SPIN_CNT_RST;
      cfg_q.energy_offset <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE:   cfg_q.energy_mode   <= cfg_data_i[0];
        REG_SPINS:  cfg_q.spin_count    <= cfg_data_i[SPIN_CNT_W-1:0];
        REG_OFFSET: cfg_q.energy_offset <= signed'(cfg_data_i[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  // Coefficient load: drop entries outside the store
  assign load_we = in_acc && (in_word_i.cmd == CMD_LOAD)
                && (32'(in_word_i.row_index) < MAX_SPINS)
                && (32'(in_word_i.col_index) < MAX_SPINS);
  assign wr_addr = {IDX_W'(in_word_i.row_index), IDX_W'(in_word_i.col_index)};
  assign wr_data = COEF_WIDTH'(in_word_i.coef_value);

  isqe_coef_mem #(
    .MAX_SPINS  (MAX_SPINS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  isqe_seq #(
    .MAX_SPINS  (MAX_SPINS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && (in_word_i.cmd == CMD_EVAL)),
    .cand_i     (in_word_i.candidate),
    .cfg_i      (cfg_q),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .res_take_i (res_take),
    .stat_o     (stat),
    .energy_o   (energy),
    .cand_o     (cand_res)
  );

  // Output register
  assign res_take = stat.res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_word_q.energy         <= energy;
      out_word_q.candidate_echo <= cand_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/core/isqe_checker.sv =====
module isqe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input isqe_pkg::in_word_t              in_word_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input isqe_pkg::out_word_t             out_word_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);
  import isqe_pkg::*;

  // A stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // An accepted evaluate keeps the input busy next cycle
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_word_i.cmd == CMD_EVAL) |=> in_stall_o)
    else $error("evaluate word did not occupy the block");

  // A load taken with no result pending produces no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_word_i.cmd == CMD_LOAD) && !out_valid_o
    |=> !out_valid_o)
    else $error("load word produced a result");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind ising_qubo_energy_evaluator isqe_checker u_isqe_checker (.*);

// ===== tb/sv/testbench.sv =====
module testbench;
  import isqe_pkg::*;

  localparam int NUM_SPINS = DEF_MAX_SPINS;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;
  localparam logic signed [COEF_IN_W-1:0] COEF_MAX = {1'b0, {(COEF_IN_W-1){1'b1}}};
  localparam logic signed [COEF_IN_W-1:0] COEF_MIN = {1'b1, {(COEF_IN_W-1){1'b0}}};
  localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
  localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};
  localparam longint ENERGY_MAX = (longint'(1) <<< (ENERGY_W-1)) - 1;
  localparam longint ENERGY_MIN = -ENERGY_MAX - 1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_word_t              in_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_word_t             out_word_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ising_qubo_energy_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Words waiting to be sent, and energies waiting to come back
  in_word_t  pending_words[$];
  out_word_t expected_energies[$];

  // Mirror of the block's registers and coefficient store
  logic                       cfg_mode;
  logic [SPIN_CNT_W-1:0]      cfg_spins;
  logic signed [OFFSET_W-1:0] cfg_offset;
  logic signed [COEF_IN_W-1:0] coef_mirror [NUM_SPINS][NUM_SPINS];

  // Generator side: which entries have been loaded, and the active spin count
  bit written [NUM_SPINS][NUM_SPINS];
  int gen_spins;

  int send_idle_pct;
  int recv_stall_pct;
  int fails;
  int quiet_cycles;
  logic in_taken;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Energy of one candidate under the mirrored coefficients and settings
  function automatic out_word_t qubo_ising_energy(logic [CAND_W-1:0] cand);
    out_word_t res;
    longint    acc;
    int        n;
    logic      bj;
    logic      bk;
    acc = 0;
    n = (cfg_spins > NUM_SPINS) ? NUM_SPINS : int'(cfg_spins);
    for (int j = 0; j < n; j++) begin
      bj = cand[n-1-j];
      for (int k = j; k < n; k++) begin
        bk = cand[n-1-k];
        if (cfg_mode == MODE_ISING) begin
          // diagonal uses s_j alone; off-diagonal product is -1 when bits differ
          if ((k == j) ? bj : (bj ^ bk)) acc -= coef_mirror[j][k];
          else acc += coef_mirror[j][k];
        end else if (bj && bk) begin
          acc += coef_mirror[j][k];
        end
      end
    end
    if (cfg_mode == MODE_QUBO) acc += cfg_offset;
    if (acc > ENERGY_MAX) acc = ENERGY_MAX;
    if (acc < ENERGY_MIN) acc = ENERGY_MIN;
    res.energy = ENERGY_W'(acc);
    res.candidate_echo = cand;
    return res;
  endfunction

  // Word driver: holds a stalled word, otherwise sends or idles
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: mirror updates, prediction, result check, watchdog
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      in_taken <= in_valid_i && !in_stall_o;

      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          REG_MODE:   cfg_mode = cfg_data_i[0];
          REG_SPINS:  cfg_spins = cfg_data_i[SPIN_CNT_W-1:0];
          REG_OFFSET: cfg_offset = cfg_data_i[OFFSET_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        if (in_word_i.cmd == CMD_LOAD) begin
          coef_mirror[in_word_i.row_index][in_word_i.col_index] = in_word_i.coef_value;
        end else begin
          expected_energies.push_back(qubo_ising_energy(in_word_i.candidate));
        end
      end

      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_energies.size() == 0) begin
          fails++;
          $display("%0t: unexpected result energy %0d candidate %h", $time,
                   out_word_o.energy, out_word_o.candidate_echo);
        end else begin
          want = expected_energies.pop_front();
          if (out_word_o.energy !== want.energy) begin
            fails++;
            $display("%0t: energy mismatch expected %0d actual %0d", $time,
                     want.energy, out_word_o.energy);
          end
          if (out_word_o.candidate_echo !== want.candidate_echo) begin
            fails++;
            $display("%0t: candidate_echo mismatch expected %h actual %h", $time,
                     want.candidate_echo, out_word_o.candidate_echo);
          end
        end
      end

      if (moved) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  function automatic logic signed [COEF_IN_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      3: return '1;
      default: return COEF_IN_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(int r, int c, logic signed [COEF_IN_W-1:0] v);
    in_word_t w;
    w.cmd        = CMD_LOAD;
    w.row_index  = IDX_IN_W'(r);
    w.col_index  = IDX_IN_W'(c);
    w.coef_value = v;
    w.candidate  = CAND_W'($urandom);
    pending_words.push_back(w);
    written[r][c] = 1'b1;
  endtask

  // Loads any coefficient the evaluation would read but was never written
  task automatic queue_eval(logic [CAND_W-1:0] cand);
    in_word_t w;
    for (int j = 0; j < gen_spins; j++) begin
      for (int k = j; k < gen_spins; k++) begin
        if (!written[j][k]) queue_load(j, k, pick_coef());
      end
    end
    w.cmd        = CMD_EVAL;
    w.row_index  = IDX_IN_W'($urandom);
    w.col_index  = IDX_IN_W'($urandom);
    w.coef_value = COEF_IN_W'($urandom);
    w.candidate  = cand;
    pending_words.push_back(w);
  endtask

  task automatic random_words(int count);
    int r;
    int c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 40) begin
        if (gen_spins > 0 && $urandom_range(0, 9) < 7) begin
          r = $urandom_range(0, gen_spins - 1);
          c = $urandom_range(r, gen_spins - 1);
        end else begin
          r = $urandom_range(0, NUM_SPINS - 1);
          c = $urandom_range(0, NUM_SPINS - 1);
        end
        queue_load(r, c, pick_coef());
      end else if ($urandom_range(0, 9) == 0) begin
        queue_eval($urandom_range(0, 1) ? '1 : '0);
      end else begin
        queue_eval(CAND_W'($urandom));
      end
    end
  endtask

  // Wait until every word is sent and every energy has come back
  task automatic drain();
    while (!(pending_words.size() == 0 && !in_valid_i && expected_energies.size() == 0))
      @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Registers change only once the block has gone idle
  task automatic configure(logic mode, int spins, logic signed [OFFSET_W-1:0] offset,
                           int send_pct, int recv_pct);
    logic [CFG_DATA_W-1:0] data;
    drain();
    repeat (8) @(posedge clk_i);
    data = $urandom;
    data[0] = mode;
    write_reg(REG_MODE, data);
    data = $urandom;
    data[SPIN_CNT_W-1:0] = SPIN_CNT_W'(spins);
    write_reg(REG_SPINS, data);
    write_reg(REG_OFFSET, offset);
    gen_spins = (spins > NUM_SPINS) ? NUM_SPINS : spins;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_taken       = 1'b0;
    cfg_mode       = MODE_ISING;
    cfg_spins      = SPIN_CNT_RST;
    cfg_offset     = '0;
    gen_spins      = NUM_SPINS;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fails          = 0;
    quiet_cycles   = 0;
    foreach (coef_mirror[j, k]) coef_mirror[j][k] = '0;
    foreach (written[j, k]) written[j][k] = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: coefficient extremes, index extremes, lower-triangle load
    configure(MODE_ISING, 2, '0, 0, 0);
    queue_load(0, 0, COEF_MAX);
    queue_load(0, 1, COEF_MIN);
    queue_load(1, 1, '1);
    queue_load(1, 0, 24'sh5A5A5A);
    queue_load(15, 15, COEF_MIN);
    queue_load(0, 15, COEF_MAX);
    queue_eval(16'h0000);
    queue_eval(16'h0001);
    queue_eval(16'h0002);
    queue_eval(16'h0003);
    queue_eval(16'hFFFC);
    queue_eval(16'hFFFF);

    // QUBO form with offset extremes, then zero spin count in both modes
    configure(MODE_QUBO, 2, OFFSET_MAX, 0, 0);
    queue_eval(16'h0003);
    queue_eval(16'h0000);
    configure(MODE_QUBO, 0, OFFSET_MIN, 0, 0);
    queue_eval(16'hFFFF);
    configure(MODE_ISING, 0, OFFSET_MAX, 0, 0);
    queue_eval(16'h1234);

    // Random phases over settings and idling styles
    configure(MODE_ISING, 4, OFFSET_W'($urandom), 0, 0);
    random_words(200);
    configure(MODE_QUBO, 3, OFFSET_MAX, 72, 0);
    random_words(100);
    drain();
    random_words(100);
    configure(MODE_ISING, 16, '0, 0, 72);
    random_words(120);
    configure(MODE_QUBO, 1, OFFSET_MIN, 24, 24);
    random_words(200);
    configure(MODE_ISING, 31, OFFSET_W'($urandom), 0, 0);
    random_words(80);
    configure(MODE_QUBO, 6, OFFSET_W'($urandom), 72, 0);
    random_words(250);
    configure(MODE_ISING, 5, OFFSET_W'($urandom), 0, 72);
    random_words(250);
    configure(MODE_QUBO, 16, OFFSET_W'($urandom), 24, 24);
    random_words(100);
    configure(MODE_ISING, 7, OFFSET_W'($urandom), 24, 24);
    random_words(250);
    configure(MODE_QUBO, 2, OFFSET_W'($urandom), 0, 0);
    random_words(150);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_energies.size() != 0) begin
      fails++;
      $display("%0t: %0d expected results never arrived", $time, expected_energies.size());
    end
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
